// ===== sv/siph_pkg.sv =====
// Package: SipHash-2-4 constants, lane/pipeline types and round functions.
`default_nettype none
package siph_pkg;

  localparam logic [63:0] SIP_C0        = 64'h736F_6D65_7073_6575;
  localparam logic [63:0] SIP_C1        = 64'h646F_7261_6E64_6F6D;
  localparam logic [63:0] SIP_C2        = 64'h6C79_6765_6E65_7261;
  localparam logic [63:0] SIP_C3        = 64'h7465_6462_7974_6573;
  localparam logic [63:0] SIP_FINAL_XOR = 64'h0000_0000_0000_00FF;
  localparam logic [63:0] KEY_LOW_RST   = 64'h0706_0504_0302_0100;
  localparam logic [63:0] KEY_HIGH_RST  = 64'h0F0E_0D0C_0B0A_0908;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned LEN_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] FULL_BYTES = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW  = 2'd0,
    CFG_KEY_HIGH = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } lanes_t;

  // last word handed from the absorb stage to finalization
  typedef struct packed {
    lanes_t           lanes;
    logic [LEN_W-1:0] len;
    logic             len_block;  // full final word: length-only block still due
  } fin_item_t;

  typedef struct packed {
    logic s0_full;
    logic msg_open;
  } stat_t;

  function automatic lanes_t sip_mix(input lanes_t s);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
    lanes_t      r;
    a = s.v0;
    b = s.v1;
    c = s.v2;
    d = s.v3;
    a = a + b;
    b = {b[50:0], b[63:51]};
    b = b ^ a;
    a = {a[31:0], a[63:32]};
    c = c + d;
    d = {d[47:0], d[63:48]};
    d = d ^ c;
    a = a + d;
    d = {d[42:0], d[63:43]};
    d = d ^ a;
    c = c + b;
    b = {b[46:0], b[63:47]};
    b = b ^ c;
    c = {c[31:0], c[63:32]};
    r.v0 = a;
    r.v1 = b;
    r.v2 = c;
    r.v3 = d;
    return r;
  endfunction

  function automatic lanes_t sip_two_rounds(input lanes_t s);
    return sip_mix(sip_mix(s));
  endfunction

  function automatic lanes_t sip_absorb(input lanes_t s, input logic [63:0] m);
    lanes_t t;
    t    = s;
    t.v3 = t.v3 ^ m;
    t    = sip_two_rounds(t);
    t.v0 = t.v0 ^ m;
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== sv/siph_ifs.sv =====
// Interfaces: message word input, digest output and key write channels.
`default_nettype none
interface siph_in_if;
  import siph_pkg::*;
  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   message_word;
  logic [COUNT_W-1:0]  byte_count;
  logic                last_word;
  modport source (output valid, output message_word, output byte_count,
                  output last_word, input ready);
  modport sink   (input valid, input message_word, input byte_count,
                  input last_word, output ready);
endinterface

interface siph_out_if;
  import siph_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] hash_value;
  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

interface siph_cfg_if;
  import siph_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/siphash_2_4_stream_core.sv =====
// Top level: keyed SipHash-2-4 stream engine with key registers and assertions.
//
// Usage:
//   in_chan  - message words, little-endian, first byte in bits 7:0. One word
//              per handshake. last_word closes the message; on that word
//              byte_count (0..8, larger saturates to 8) gives the valid low
//              bytes. The next word opens a new message.
//   out_chan - one 64-bit digest per message, nothing for other words.
//   cfg_chan - key writes: index 0 = key low half, index 1 = key high half;
//              always ready. The key is sampled on the first word of a
//              message, so write it between messages.
// Throughput: one word per cycle, including last words, unless a last word is held (see Stall).
// Path: a last word passes the input register, the length/xor stage, two round
//   stages and the output register before out_chan.valid rises.
// Reset (rst_n low, synchronous): pipeline emptied, no message open, key
//   returns to 0x0F0E..0908 / 0x0706..0100.
// Stall: a held digest stays in the output register while the pipeline
//   keeps filling; only a last word finding the finalization stages full is
//   held in the input register, and in_chan.ready drops then.
`default_nettype none
module siphash_2_4_stream_core (
  input  wire logic clk,
  input  wire logic rst_n,
  siph_in_if.sink    in_chan,
  siph_out_if.source out_chan,
  siph_cfg_if.sink   cfg_chan
);
  import siph_pkg::*;

  logic [WORD_W-1:0] key_low_r;
  logic [WORD_W-1:0] key_high_r;

  logic      fin_vld;
  logic      fin_rdy;
  fin_item_t fin_item;
  stat_t     stat;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= KEY_LOW_RST;
      key_high_r <= KEY_HIGH_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_idx_t'(cfg_chan.index))
        CFG_KEY_LOW:  key_low_r  <= cfg_chan.data;
        CFG_KEY_HIGH: key_high_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  siph_absorb u_absorb (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_word   (in_chan.message_word),
    .in_count  (in_chan.byte_count),
    .in_last   (in_chan.last_word),
    .key_low   (key_low_r),
    .key_high  (key_high_r),
    .fin_valid (fin_vld),
    .fin_ready (fin_rdy),
    .fin_item  (fin_item),
    .stat      (stat)
  );

  siph_final u_final (
    .clk       (clk),
    .rst_n     (rst_n),
    .fin_valid (fin_vld),
    .fin_ready (fin_rdy),
    .fin_item  (fin_item),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_hash  (out_chan.hash_value)
  );

  // input backpressure only comes from a last word waiting on finalization
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (stat.s0_full && fin_vld && !fin_rdy))
    else $error("input stalled without a blocked last word");

  // handing a last word to finalization closes the message
  a_msg_close: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_vld && fin_rdy) |=> !stat.msg_open)
    else $error("message still open after last word");

  // reset empties the pipeline and closes any message
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!out_chan.valid && !stat.msg_open && !stat.s0_full))
    else $error("state not cleared by reset");

endmodule
`default_nettype wire

// ===== sv/siph_absorb.sv =====
// Absorb stage: input register, lane state, one block compressed per word.
`default_nettype none
module siph_absorb (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [63:0]                  in_word,
  input  wire logic [3:0]                   in_count,
  input  wire logic                         in_last,
  input  wire logic [63:0]                  key_low,
  input  wire logic [63:0]                  key_high,
  output logic                              fin_valid,
  input  wire logic                         fin_ready,
  output siph_pkg::fin_item_t               fin_item,
  output siph_pkg::stat_t                   stat
);
  import siph_pkg::*;

  logic               s0_vld_r;
  logic               s0_vld_nxt;
  logic [WORD_W-1:0]  s0_word_r;
  logic [COUNT_W-1:0] s0_cnt_r;
  logic               s0_last_r;

  lanes_t             lanes_r;
  logic [LEN_W-1:0]   len_r;
  logic               open_r;

  lanes_t             base;
  lanes_t             absorbed;
  logic [LEN_W-1:0]   len_base;
  logic [LEN_W-1:0]   len_nxt;
  logic [COUNT_W-1:0] cnt_sat;
  logic [COUNT_W-1:0] len_add;
  logic               full;
  logic [WORD_W-1:0]  tail_mask;
  logic [WORD_W-1:0]  block;
  logic               s0_go;
  logic               in_take;

  always_comb begin
    if (open_r) begin
      base     = lanes_r;
      len_base = len_r;
    end else begin
      base.v0  = key_low ^ SIP_C0;
      base.v1  = key_high ^ SIP_C1;
      base.v2  = key_low ^ SIP_C2;
      base.v3  = key_high ^ SIP_C3;
      len_base = '0;
    end
    cnt_sat   = (s0_cnt_r > FULL_BYTES) ? FULL_BYTES : s0_cnt_r;
    full      = !s0_last_r || (cnt_sat == FULL_BYTES);
    len_add   = full ? FULL_BYTES : cnt_sat;
    len_nxt   = len_base + {{(LEN_W-COUNT_W){1'b0}}, len_add};
    // only used for a short tail, where cnt_sat is 0..7
    tail_mask = ~({WORD_W{1'b1}} << {cnt_sat[2:0], 3'b000});
    if (full) begin
      block = s0_word_r;
    end else begin
      block = (s0_word_r & tail_mask) | {len_nxt, {(WORD_W-LEN_W){1'b0}}};
    end
    absorbed = sip_absorb(base, block);
  end

  always_comb begin
    fin_valid          = s0_vld_r && s0_last_r;
    fin_item.lanes     = absorbed;
    fin_item.len       = len_nxt;
    fin_item.len_block = full;
    s0_go              = s0_vld_r && (!s0_last_r || fin_ready);
    in_ready           = !s0_vld_r || s0_go;
    in_take            = in_valid && in_ready;
    if (in_take) begin
      s0_vld_nxt = 1'b1;
    end else if (s0_go) begin
      s0_vld_nxt = 1'b0;
    end else begin
      s0_vld_nxt = s0_vld_r;
    end
    stat.s0_full  = s0_vld_r;
    stat.msg_open = open_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      open_r   <= 1'b0;
      len_r    <= '0;
      lanes_r  <= '0;
    end else begin
      s0_vld_r <= s0_vld_nxt;
      if (s0_go) begin
        lanes_r <= absorbed;
        len_r   <= len_nxt;
        open_r  <= !s0_last_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_word_r <= in_word;
      s0_cnt_r  <= in_count;
      s0_last_r <= in_last;
    end
  end

endmodule
`default_nettype wire

// ===== sv/siph_final.sv =====
// Finalization pipeline: length block, four rounds, lane fold, output register.
`default_nettype none
module siph_final (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                fin_valid,
  output logic                     fin_ready,
  input  wire siph_pkg::fin_item_t fin_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [63:0]              out_hash
);
  import siph_pkg::*;

  logic              f1_vld_r;
  logic              f2_vld_r;
  logic              f3_vld_r;
  logic              out_vld_r;
  fin_item_t         f1_item_r;
  lanes_t            f2_lanes_r;
  lanes_t            f3_lanes_r;
  logic [WORD_W-1:0] hash_r;

  lanes_t            f2_lanes_nxt;
  lanes_t            f3_lanes_nxt;
  lanes_t            last_rounds;
  logic [WORD_W-1:0] hash_nxt;
  lanes_t            len_absorbed;

  logic out_free;
  logic f3_adv;
  logic f3_rdy;
  logic f2_adv;
  logic f2_rdy;
  logic f1_adv;
  logic fin_take;

  always_comb begin
    out_free = !out_vld_r || out_ready;
    f3_adv   = f3_vld_r && out_free;
    f3_rdy   = !f3_vld_r || f3_adv;
    f2_adv   = f2_vld_r && f3_rdy;
    f2_rdy   = !f2_vld_r || f2_adv;
    f1_adv   = f1_vld_r && f2_rdy;
    fin_ready = !f1_vld_r || f1_adv;
    fin_take  = fin_valid && fin_ready;
  end

  // stage 1: length-only block after a full final word, then the constant 0xFF xor into v2
  always_comb begin
    len_absorbed = sip_absorb(f1_item_r.lanes,
                              {f1_item_r.len, {(WORD_W-LEN_W){1'b0}}});
    f2_lanes_nxt = f1_item_r.len_block ? len_absorbed : f1_item_r.lanes;
    f2_lanes_nxt.v2 = f2_lanes_nxt.v2 ^ SIP_FINAL_XOR;
  end

  // stages 2 and 3: two finalization rounds each
  always_comb begin
    f3_lanes_nxt = sip_two_rounds(f2_lanes_r);
    last_rounds  = sip_two_rounds(f3_lanes_r);
    hash_nxt     = last_rounds.v0 ^ last_rounds.v1 ^ last_rounds.v2 ^ last_rounds.v3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r  <= 1'b0;
      f2_vld_r  <= 1'b0;
      f3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (fin_take) begin
        f1_vld_r <= 1'b1;
      end else if (f1_adv) begin
        f1_vld_r <= 1'b0;
      end
      if (f1_adv) begin
        f2_vld_r <= 1'b1;
      end else if (f2_adv) begin
        f2_vld_r <= 1'b0;
      end
      if (f2_adv) begin
        f3_vld_r <= 1'b1;
      end else if (f3_adv) begin
        f3_vld_r <= 1'b0;
      end
      if (f3_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_take) begin
      f1_item_r <= fin_item;
    end
    if (f1_adv) begin
      f2_lanes_r <= f2_lanes_nxt;
    end
    if (f2_adv) begin
      f3_lanes_r <= f3_lanes_nxt;
    end
    if (f3_adv) begin
      hash_r <= hash_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_hash  = hash_r;

endmodule
`default_nettype wire
